@@ design/dmc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Direct-mapped cache tag cost model: shared definitions
// Widths, register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int DEF_BLOCK_BITS = 4;
  localparam int DEF_INDEX_BITS = 8;

  localparam int ADDR_W    = 32;
  localparam int COUNT_W   = 4;
  localparam int CFG_W     = 16;
  localparam int COST_OUT_W = 32;
  localparam int TALLY_W   = 4;
  localparam int MAX_BYTES = 8;
  localparam int SPAN_W    = 3;

  // Largest access cost is eight lines of one lookup plus two line moves of
  // at most eight block bits each, which stays below 2^24.
  localparam int COST_W = 24;

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  localparam logic [CFG_W-1:0] HIT_COST_RST  = CFG_W'(1);
  localparam logic [CFG_W-1:0] MISS_COST_RST = CFG_W'(10);

  typedef enum logic [0:0] {
    REG_HIT_COST  = 1'b0,
    REG_MISS_COST = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] hit_cost;
    logic [CFG_W-1:0] miss_cost;
  } cfg_t;

endpackage
`default_nettype wire

@@ design/dmc_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Direct-mapped cache tag cost model: stream interfaces
// Access request channel and access result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmc_req_if import dmc_pkg::*;;
  logic               valid;
  logic               ready;
  logic               action;
  logic [ADDR_W-1:0]  address;
  logic [COUNT_W-1:0] byte_count;

  modport source (output valid, action, address, byte_count, input ready);
  modport sink   (input valid, action, address, byte_count, output ready);
endinterface

interface dmc_rsp_if import dmc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  missed;
  logic [COST_OUT_W-1:0] total_cost;
  logic [TALLY_W-1:0]    lines_touched;
  logic [TALLY_W-1:0]    writebacks;

  modport source (output valid, missed, total_cost, lines_touched, writebacks,
                  input ready);
  modport sink   (input valid, missed, total_cost, lines_touched, writebacks,
                  output ready);
endinterface
`default_nettype wire

@@ design/dmc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/dmc_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Direct-mapped cache tag cost model: configuration registers
// APB-style register file holding the lookup cost and the line move cost.
// ----------------------------------------------------------------------------
module dmc_cfg import dmc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hit_cost  <= HIT_COST_RST;
      cfg.miss_cost <= MISS_COST_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HIT_COST:  cfg.hit_cost  <= pwdata[CFG_W-1:0];
        REG_MISS_COST: cfg.miss_cost <= pwdata[CFG_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HIT_COST:  prdata = APB_DATA_W'(cfg.hit_cost);
      REG_MISS_COST: prdata = APB_DATA_W'(cfg.miss_cost);
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/direct_mapped_cache_tag_cost_model.sv @@
`default_nettype none
// The result of an access touching L lines (1 to 8) enters the output register
// once its last line is looked up and that register is free: the first tag
// entry is read at the transfer, then each line gets one tag memory
// read-modify-write. A request is taken only when idle, after the previous
// result is loaded. After reset all 2^INDEX_BITS tag memory entries are swept
// clean (256 by default), with req.ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// Direct-mapped cache tag cost model
// Splits each access into cache lines, looks each line up in a direct-mapped
// write-back tag memory and reports misses, writebacks and access cost.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_cost_model import dmc_pkg::*; #(
  parameter int BLOCK_BITS = DEF_BLOCK_BITS,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  dmc_req_if.sink                    req,
  dmc_rsp_if.source                  rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int LA_W   = ADDR_W - BLOCK_BITS;
  localparam int TAG_W  = LA_W - INDEX_BITS;
  localparam int IDX_W  = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int DEPTH  = 1 << INDEX_BITS;
  localparam int WORD_W = TAG_W + 2;
  localparam logic [LA_W-1:0]  IDX_MASK = LA_W'((1 << INDEX_BITS) - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  cfg_t cfg;

  state_t              state;
  logic [IDX_W-1:0]    clr_idx;
  logic [LA_W-1:0]     cur_line;
  logic [LA_W-1:0]     last_line;
  logic                is_write;
  logic                fwd_sel;
  entry_t              fwd_word;
  logic [COST_W-1:0]   block_cost;
  logic [COST_W-1:0]   acc_cost;
  logic [TALLY_W-1:0]  acc_lines;
  logic [TALLY_W-1:0]  acc_wb;
  logic                acc_miss;

  logic                out_valid;
  logic                out_missed;
  logic [COST_W-1:0]   out_cost;
  logic [TALLY_W-1:0]  out_lines;
  logic [TALLY_W-1:0]  out_wb;

  logic                req_fire;
  logic                out_free;
  logic                load_out;
  logic [SPAN_W-1:0]   span;
  logic [ADDR_W-1:0]   last_addr;
  logic [LA_W-1:0]     first_line;

  logic [WORD_W-1:0]   ram_rdata;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;

  entry_t              cur_entry;
  entry_t              new_entry;
  logic [TAG_W-1:0]    cur_tag;
  logic [IDX_W-1:0]    cur_idx;
  logic [LA_W-1:0]     next_line;
  logic [IDX_W-1:0]    next_idx;
  logic                hit;
  logic                victim_wb;
  logic                more;
  logic [COST_W-1:0]   line_cost;
  logic [COST_W-1:0]   cost_sum;
  logic [TALLY_W-1:0]  lines_sum;
  logic [TALLY_W-1:0]  wb_sum;
  logic                miss_sum;

  dmc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dmc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign load_out  = out_free && ((state == ST_LOOK && !more) || state == ST_DONE);

  always_comb begin
    if (req.byte_count == '0) begin
      span = '0;
    end else if (req.byte_count > COUNT_W'(MAX_BYTES)) begin
      span = SPAN_W'(MAX_BYTES - 1);
    end else begin
      span = SPAN_W'(req.byte_count - COUNT_W'(1));
    end
  end

  assign last_addr  = req.address + ADDR_W'(span);
  assign first_line = LA_W'(req.address >> BLOCK_BITS);

  assign cur_entry = fwd_sel ? fwd_word : entry_t'(ram_rdata);
  assign cur_tag   = TAG_W'(cur_line >> INDEX_BITS);
  assign cur_idx   = IDX_W'(cur_line & IDX_MASK);
  assign next_line = cur_line + LA_W'(1);
  assign next_idx  = IDX_W'(next_line & IDX_MASK);
  assign hit       = cur_entry.valid && (cur_entry.tag == cur_tag);
  assign victim_wb = !hit && cur_entry.valid && cur_entry.dirty;
  assign more      = (cur_line != last_line);

  always_comb begin
    if (is_write) begin
      new_entry = '{valid: 1'b1, dirty: 1'b1, tag: cur_tag};
    end else if (!hit) begin
      new_entry = '{valid: 1'b1, dirty: 1'b0, tag: cur_tag};
    end else begin
      new_entry = cur_entry;
    end
  end

  assign line_cost = COST_W'(cfg.hit_cost)
                   + (victim_wb ? block_cost : '0)
                   + ((!hit && !is_write) ? block_cost : '0);
  assign cost_sum  = acc_cost + line_cost;
  assign lines_sum = acc_lines + TALLY_W'(1);
  assign wb_sum    = acc_wb + TALLY_W'(victim_wb);
  assign miss_sum  = acc_miss || !hit;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_idx;
    ram_wdata = new_entry;
    ram_raddr = IDX_W'(first_line & IDX_MASK);
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
      end
      ST_LOOK: begin
        ram_we    = is_write || !hit;
        ram_raddr = next_idx;
      end
      ST_IDLE, ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    block_cost <= COST_W'(cfg.miss_cost) * COST_W'(BLOCK_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      fwd_sel   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == IDX_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          fwd_sel <= 1'b0;
          if (req_fire) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          fwd_sel <= more && (next_idx == cur_idx);
          if (!more) begin
            if (out_free) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur_line  <= first_line;
      last_line <= LA_W'(last_addr >> BLOCK_BITS);
      is_write  <= req.action;
      acc_cost  <= '0;
      acc_lines <= '0;
      acc_wb    <= '0;
      acc_miss  <= 1'b0;
    end else if (state == ST_LOOK) begin
      cur_line  <= next_line;
      fwd_word  <= new_entry;
      acc_cost  <= cost_sum;
      acc_lines <= lines_sum;
      acc_wb    <= wb_sum;
      acc_miss  <= miss_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOK && !more && out_free) begin
      out_missed <= miss_sum;
      out_cost   <= cost_sum;
      out_lines  <= lines_sum;
      out_wb     <= wb_sum;
    end else if (state == ST_DONE && out_free) begin
      out_missed <= acc_miss;
      out_cost   <= acc_cost;
      out_lines  <= acc_lines;
      out_wb     <= acc_wb;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.missed        = out_missed;
  assign rsp.total_cost    = COST_OUT_W'(out_cost);
  assign rsp.lines_touched = out_lines;
  assign rsp.writebacks    = out_wb;

endmodule
`default_nettype wire

@@ dv/tb_direct_mapped_cache_tag_cost_model.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the direct-mapped cache tag cost model
// Drives read and write accesses through the request channel and predicts
// each result from a tag store kept in the testbench. The run covers
// directed corner cases, then random accesses around a small working set,
// under several cost settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_direct_mapped_cache_tag_cost_model import dmc_pkg::*;;

  localparam int BLOCK_BITS  = DEF_BLOCK_BITS;
  localparam int INDEX_BITS  = DEF_INDEX_BITS;
  localparam int LINE_COUNT  = 1 << INDEX_BITS;
  localparam int TAG_W       = ADDR_W - BLOCK_BITS - INDEX_BITS;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 20;

  typedef enum logic {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } access_kind_t;

  typedef struct packed {
    access_kind_t       action;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] byte_count;
  } access_t;

  typedef struct packed {
    logic                  missed;
    logic [COST_OUT_W-1:0] total_cost;
    logic [TALLY_W-1:0]    lines_touched;
    logic [TALLY_W-1:0]    writebacks;
  } cost_result_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  wire  [APB_DATA_W-1:0] prdata;
  wire                   pready;

  dmc_req_if req_ch ();
  dmc_rsp_if rsp_ch ();

  direct_mapped_cache_tag_cost_model #(
    .BLOCK_BITS (BLOCK_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [TAG_W-1:0]      tag_store [LINE_COUNT] = '{default: '0};
  bit                    valid_store [LINE_COUNT] = '{default: 1'b0};
  bit                    dirty_store [LINE_COUNT] = '{default: 1'b0};
  logic [CFG_W-1:0]      lookup_price = HIT_COST_RST;
  logic [CFG_W-1:0]      move_price = MISS_COST_RST;

  access_t               access_queue[$];
  cost_result_t          cost_predictions[$];
  access_t               driven_access;
  cost_result_t          oldest_prediction;
  logic [TAG_W-1:0]      hot_tags [4];
  logic [INDEX_BITS-1:0] hot_index;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  int                    error_count;
  int                    stall_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic cost_result_t charge_access(access_t acc);
    cost_result_t          outcome;
    logic [ADDR_W-1:0]     byte_addr;
    logic [ADDR_W-1:0]     line_addr;
    logic [INDEX_BITS-1:0] idx;
    logic [TAG_W-1:0]      tag;
    logic [63:0]           cost;
    logic [63:0]           block_cost;
    int unsigned           span;
    int unsigned           pos;
    bit                    hit;
    outcome = '0;
    cost = '0;
    pos = 0;
    span = (acc.byte_count > MAX_BYTES) ? MAX_BYTES : acc.byte_count;
    block_cost = 64'(move_price) * BLOCK_BITS;
    do begin
      byte_addr = acc.address + ADDR_W'(pos);
      line_addr = byte_addr >> BLOCK_BITS;
      idx = line_addr[INDEX_BITS-1:0];
      tag = byte_addr[ADDR_W-1 -: TAG_W];
      hit = valid_store[idx] && (tag_store[idx] == tag);
      outcome.lines_touched++;
      cost += lookup_price;
      if (!hit) begin
        outcome.missed = 1'b1;
        if (valid_store[idx] && dirty_store[idx]) begin
          outcome.writebacks++;
          cost += block_cost;
        end
        if (acc.action == ACC_READ) begin
          cost += block_cost;
          valid_store[idx] = 1'b1;
          dirty_store[idx] = 1'b0;
          tag_store[idx] = tag;
        end
      end
      if (acc.action == ACC_WRITE) begin
        valid_store[idx] = 1'b1;
        dirty_store[idx] = 1'b1;
        tag_store[idx] = tag;
      end
      do begin
        pos++;
        byte_addr = acc.address + ADDR_W'(pos);
      end while (pos < span && (byte_addr >> BLOCK_BITS) == line_addr);
    end while (pos < span);
    outcome.total_cost = (cost > 64'hFFFF_FFFF) ? '1 : cost[COST_OUT_W-1:0];
    return outcome;
  endfunction

  function automatic access_t random_access();
    access_t               acc;
    logic [TAG_W-1:0]      tag;
    logic [INDEX_BITS-1:0] idx;
    acc.action = access_kind_t'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      acc.byte_count = COUNT_W'($urandom_range(MAX_BYTES + 1, 15));
    end else begin
      acc.byte_count = COUNT_W'($urandom_range(0, MAX_BYTES));
    end
    if ($urandom_range(0, 4) == 0) begin
      acc.address = $urandom();
    end else begin
      tag = hot_tags[$urandom_range(0, 3)];
      idx = hot_index + INDEX_BITS'($urandom_range(0, 7));
      acc.address = {tag, idx, BLOCK_BITS'($urandom_range(0, (1 << BLOCK_BITS) - 1))};
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    error_count++;
    $display("%0t mismatch on %s: got %0h, predicted %0h", $realtime, field, seen,
             wanted);
  endtask

  task automatic push_access(input access_kind_t kind, input logic [ADDR_W-1:0] addr,
                             input int count);
    access_queue.push_back('{action: kind, address: addr, byte_count: COUNT_W'(count)});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (access_queue.size() != 0 || req_ch.valid || cost_predictions.size() != 0);
  endtask

  task automatic write_register(input reg_idx_t which, input logic [CFG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(which));
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == REG_HIT_COST) begin
      lookup_price = value;
    end else begin
      move_price = value;
    end
  endtask

  task automatic run_batch(input int send_pct, input int recv_pct, input int lookup,
                           input int move, input int items, input bit pause_midway);
    write_register(REG_HIT_COST,
                   (lookup < 0) ? CFG_W'($urandom_range(0, 65535)) : CFG_W'(lookup));
    write_register(REG_MISS_COST,
                   (move < 0) ? CFG_W'($urandom_range(0, 65535)) : CFG_W'(move));
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    hot_index = INDEX_BITS'($urandom());
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        hot_tags[k] = k[0] ? '1 : '0;
      end else begin
        hot_tags[k] = TAG_W'($urandom());
      end
    end
    for (int n = 0; n < items; n++) begin
      if (pause_midway && n == items / 2) begin
        wait_drained();
      end
      access_queue.push_back(random_access());
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        cost_predictions.push_back(charge_access(driven_access));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (access_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          driven_access = access_queue.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.action     <= driven_access.action;
          req_ch.address    <= driven_access.address;
          req_ch.byte_count <= driven_access.byte_count;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (cost_predictions.size() == 0) begin
          report_mismatch("unexpected result transfer", rsp_ch.total_cost, 0);
        end else begin
          oldest_prediction = cost_predictions.pop_front();
          if (rsp_ch.missed !== oldest_prediction.missed) begin
            report_mismatch("missed", 32'(rsp_ch.missed), 32'(oldest_prediction.missed));
          end
          if (rsp_ch.total_cost !== oldest_prediction.total_cost) begin
            report_mismatch("total_cost", rsp_ch.total_cost, oldest_prediction.total_cost);
          end
          if (rsp_ch.lines_touched !== oldest_prediction.lines_touched) begin
            report_mismatch("lines_touched", 32'(rsp_ch.lines_touched),
                            32'(oldest_prediction.lines_touched));
          end
          if (rsp_ch.writebacks !== oldest_prediction.writebacks) begin
            report_mismatch("writebacks", 32'(rsp_ch.writebacks),
                            32'(oldest_prediction.writebacks));
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_ch.valid      = 1'b0;
    req_ch.action     = 1'b0;
    req_ch.address    = '0;
    req_ch.byte_count = '0;
    rsp_ch.ready      = 1'b0;
    send_idle_pct     = 28;
    recv_idle_pct     = 77;
    error_count       = 0;
    stall_cycles      = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed accesses run under the reset cost settings.
    @(negedge clk);
    push_access(ACC_READ,  32'h0000_0000, 0);
    push_access(ACC_READ,  32'h0000_0000, 8);
    push_access(ACC_WRITE, 32'h0000_0004, 4);
    push_access(ACC_READ,  32'h0000_1000, 1);
    push_access(ACC_WRITE, 32'h0000_2000, 2);
    push_access(ACC_WRITE, 32'h0000_3000, 8);
    push_access(ACC_READ,  32'h0000_000C, 8);
    push_access(ACC_READ,  32'hFFFF_FFFC, 8);
    push_access(ACC_WRITE, 32'hFFFF_FFFF, 15);
    push_access(ACC_READ,  32'hFFFF_FFFF, 9);
    push_access(ACC_WRITE, 32'h7FFF_FFFA, 8);
    push_access(ACC_READ,  32'h8000_0000, 3);
    push_access(ACC_READ,  32'hAAAA_AAAA, 5);
    push_access(ACC_WRITE, 32'h5555_5555, 10);
    push_access(ACC_READ,  32'h5555_5555, 0);
    push_access(ACC_WRITE, 32'h0000_0000, 0);
    push_access(ACC_READ,  32'h0000_0010, 15);
    push_access(ACC_READ,  32'h0001_0000, 7);
    wait_drained();

    run_batch(28, 77, 0, 65535, 180, 1'b0);
    run_batch(28, 77, -1, -1, 150, 1'b0);
    run_batch(77, 28, 65535, 0, 180, 1'b1);
    run_batch(77, 28, 65535, 65535, 150, 1'b0);
    run_batch(0, 0, -1, -1, 180, 1'b0);
    run_batch(0, 0, 1, 10, 160, 1'b0);

    repeat (SETTLE) @(posedge clk);
    if (cost_predictions.size() != 0) begin
      report_mismatch("results never delivered", 0, cost_predictions.size());
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
